FILE: hw/rtl/pdic_pkg.sv
// ----------------------------------------------------------------------------
// pdic_pkg: shared types and codes of the PD inertia compensation unit
// Request and result structs, item kinds, mode codes and the control
// struct that the sequencer hands to the row of joint cells.
// ----------------------------------------------------------------------------
package pdic_pkg;

    localparam logic [1:0] KIND_JOINT   = 2'd0;
    localparam logic [1:0] KIND_INERTIA = 2'd1;
    localparam logic [1:0] KIND_COMPUTE = 2'd2;

    localparam logic [1:0] MODE_FULL = 2'd0;
    localparam logic [1:0] MODE_DIAG = 2'd1;
    localparam logic [1:0] MODE_OFF  = 2'd2;

    localparam logic [1:0] CFG_KP    = 2'd0;
    localparam logic [1:0] CFG_KD    = 2'd1;
    localparam logic [1:0] CFG_MODE  = 2'd2;
    localparam logic [1:0] CFG_COUNT = 2'd3;

    // Integer parts of the gain reset values.
    localparam int KP_RESET_INT = 100;
    localparam int KD_RESET_INT = 20;

    // Joint count is at most eight, so four bits hold it.
    localparam int CNT_W = 4;
    // Accumulator width: eight shifted 64-bit products plus gravity.
    localparam int ACC_W = 68;

    typedef struct packed {
        logic [1:0]         kind;
        logic [2:0]         row;
        logic [2:0]         col;
        logic signed [31:0] goal_position;
        logic signed [31:0] goal_velocity;
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic signed [31:0] gravity_torque;
        logic signed [31:0] inertia_value;
    } t_in_req;

    typedef struct packed {
        logic [2:0]         joint;
        logic signed [31:0] torque;
        logic               saturated;
        logic               last;
    } t_out_res;

    typedef struct packed {
        logic             load_joint;
        logic             load_inertia;
        logic             gam_mul;
        logic             gam_fin;
        logic             rot_load;
        logic             mul_en;
        logic             res_load;
        logic             res_shift;
        logic [1:0]       mode;
        logic [CNT_W-1:0] count;
    } t_cell_ctrl;

endpackage

FILE: hw/rtl/pdic_cell.sv
// ----------------------------------------------------------------------------
// pdic_cell: one joint cell
// Holds the joint data, one inertia row and gamma of its joint. Gamma values
// circulate around the ring of cells; each cell multiplies what passes by
// its inertia row and accumulates. Results shift toward cell zero.
// ----------------------------------------------------------------------------
module pdic_cell
    import pdic_pkg::*;
#(
    parameter int MAX_JOINTS = 8,
    parameter int FRAC_BITS  = 16,
    parameter int IDX        = 0
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  t_cell_ctrl                            i_ctrl,
    input  t_in_req                               i_req,
    input  logic [30:0]                           i_kp,
    input  logic [30:0]                           i_kd,
    input  logic signed [31:0]                    i_circ,
    input  logic [$clog2(MAX_JOINTS+1)-1:0]       i_circ_idx,
    output logic signed [31:0]                    o_circ,
    output logic [$clog2(MAX_JOINTS+1)-1:0]       o_circ_idx,
    input  logic                                  i_any_in,
    output logic                                  o_any_out,
    input  logic                                  i_any_all,
    input  logic signed [31:0]                    i_res_torque,
    input  logic                                  i_res_sat,
    output logic signed [31:0]                    o_res_torque,
    output logic                                  o_res_sat
);

    localparam int IW = $clog2(MAX_JOINTS + 1);
    localparam int CW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic signed [31:0] r_gp, r_gv, r_p, r_v, r_grav, r_gamma;
    logic signed [31:0] r_row [MAX_JOINTS];
    logic               r_gclip;
    logic signed [64:0] r_pkp, r_pkd;
    logic signed [63:0] r_prod;
    logic               r_pv;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [31:0] r_circ;
    logic [IW-1:0]      r_circ_idx;
    logic signed [31:0] r_res_torque;
    logic               r_res_sat;

    logic signed [32:0] ep, ev;
    logic signed [65:0] gsum;
    logic               use_prod;
    logic signed [ACC_W-1:0] tsum;
    logic               tflag;
    logic [IW-1:0]      count_ext;

    assign count_ext = IW'(i_ctrl.count);
    assign ep = 33'(r_gp) - 33'(r_p);
    assign ev = 33'(r_gv) - 33'(r_v);
    assign gsum = 66'(r_pkp >>> FRAC_BITS) + 66'(r_pkd >>> FRAC_BITS);

    always_comb begin
        case (i_ctrl.mode)
            MODE_FULL: use_prod = (r_circ_idx < count_ext);
            MODE_DIAG: use_prod = (r_circ_idx == MY_IDX);
            default:   use_prod = 1'b0;
        endcase
    end

    always_comb begin
        if (i_ctrl.mode == MODE_FULL || i_ctrl.mode == MODE_DIAG) begin
            tsum = r_acc + ACC_W'(r_grav);
        end else begin
            tsum = ACC_W'(r_gamma) + ACC_W'(r_grav);
        end
        tflag = (i_ctrl.mode == MODE_FULL) ? i_any_all : r_gclip;
        if (tsum > ACC_W'(64'sd2147483647) || tsum < ACC_W'(-64'sd2147483648)) begin
            tflag = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_joint && i_req.row == 3'(IDX) && IDX < 8) begin
            r_gp   <= i_req.goal_position;
            r_gv   <= i_req.goal_velocity;
            r_p    <= i_req.position;
            r_v    <= i_req.velocity;
            r_grav <= i_req.gravity_torque;
        end
        if (i_ctrl.load_inertia && i_req.row == 3'(IDX) && IDX < 8
            && 32'(i_req.col) < 32'(MAX_JOINTS)) begin
            r_row[i_req.col[CW-1:0]] <= i_req.inertia_value;
        end
        if (i_ctrl.gam_mul) begin
            r_pkp <= 65'(ep) * 65'($signed({1'b0, i_kp}));
            r_pkd <= 65'(ev) * 65'($signed({1'b0, i_kd}));
        end
        if (i_ctrl.gam_fin) begin
            if (gsum > 66'sd2147483647) begin
                r_gamma <= 32'sh7fffffff;
                r_gclip <= 1'b1;
            end else if (gsum < -66'sd2147483648) begin
                r_gamma <= 32'sh80000000;
                r_gclip <= 1'b1;
            end else begin
                r_gamma <= gsum[31:0];
                r_gclip <= 1'b0;
            end
        end
        if (i_ctrl.rot_load) begin
            r_circ     <= r_gamma;
            r_circ_idx <= MY_IDX;
            r_acc      <= '0;
        end else begin
            if (i_ctrl.mul_en) begin
                r_circ     <= i_circ;
                r_circ_idx <= i_circ_idx;
            end
            if (r_pv) begin
                r_acc <= r_acc + ACC_W'(r_prod >>> FRAC_BITS);
            end
        end
        r_prod <= 64'(r_row[r_circ_idx[CW-1:0]]) * 64'(r_circ);
        if (i_ctrl.res_load) begin
            r_res_torque <= tsum[31:0];
            if (tsum > ACC_W'(64'sd2147483647)) begin
                r_res_torque <= 32'sh7fffffff;
            end else if (tsum < ACC_W'(-64'sd2147483648)) begin
                r_res_torque <= 32'sh80000000;
            end
            r_res_sat <= tflag;
        end else if (i_ctrl.res_shift) begin
            r_res_torque <= i_res_torque;
            r_res_sat    <= i_res_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_ctrl.mul_en && !i_ctrl.rot_load && use_prod;
        end
    end

    assign o_circ       = r_circ;
    assign o_circ_idx   = r_circ_idx;
    assign o_any_out    = i_any_in | (r_gclip && MY_IDX < count_ext);
    assign o_res_torque = r_res_torque;
    assign o_res_sat    = r_res_sat;

endmodule

FILE: hw/rtl/pdic_ctrl.sv
// ----------------------------------------------------------------------------
// pdic_ctrl: sequencer and output register
// Accepts requests, steps the cells through gamma, the ring of products and
// the torque sum, then shifts the torques out of cell zero one by one.
// ----------------------------------------------------------------------------
module pdic_ctrl
    import pdic_pkg::*;
#(
    parameter int MAX_JOINTS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_in_req            i_req,
    output logic               o_stall,
    output logic               o_valid,
    output t_out_res           o_res,
    input  logic               i_stall,
    input  logic [1:0]         i_mode,
    input  logic [3:0]         i_count,
    input  logic signed [31:0] i_head_torque,
    input  logic               i_head_sat,
    output t_cell_ctrl         o_ctrl
);

    localparam int NMAX = (MAX_JOINTS < 8) ? MAX_JOINTS : 8;
    localparam int SW   = $clog2(MAX_JOINTS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_G1, S_G2, S_ROT, S_MUL, S_RES, S_EMIT
    } t_state;

    t_state           r_state;
    logic [SW-1:0]    r_step;
    logic [CNT_W-1:0] r_k;
    logic [1:0]       r_mode;
    logic [CNT_W-1:0] r_n;
    logic             r_valid;
    t_out_res         r_res;

    logic [CNT_W-1:0] n_clamp;
    logic             take;
    logic             accept;

    always_comb begin
        if (i_count == '0) begin
            n_clamp = CNT_W'(1);
        end else if (32'(i_count) > NMAX) begin
            n_clamp = CNT_W'(NMAX);
        end else begin
            n_clamp = i_count;
        end
    end

    assign accept = (r_state == S_IDLE) && i_valid;
    assign take   = (r_state == S_EMIT) && (!r_valid || !i_stall);

    always_comb begin
        o_ctrl.load_joint   = accept && i_req.kind == KIND_JOINT;
        o_ctrl.load_inertia = accept && i_req.kind == KIND_INERTIA;
        o_ctrl.gam_mul      = r_state == S_G1;
        o_ctrl.gam_fin      = r_state == S_G2;
        o_ctrl.rot_load     = r_state == S_ROT;
        o_ctrl.mul_en       = (r_state == S_MUL) && (32'(r_step) < MAX_JOINTS);
        o_ctrl.res_load     = r_state == S_RES;
        o_ctrl.res_shift    = take;
        o_ctrl.mode         = r_mode;
        o_ctrl.count        = r_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_step  <= '0;
            r_k     <= '0;
            r_mode  <= MODE_FULL;
            r_n     <= CNT_W'(1);
        end else begin
            if (take) begin
                r_valid <= 1'b1;
            end else if (r_valid && !i_stall) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept && i_req.kind == KIND_COMPUTE) begin
                        r_mode  <= (i_mode == MODE_FULL || i_mode == MODE_DIAG)
                                   ? i_mode : MODE_OFF;
                        r_n     <= n_clamp;
                        r_state <= S_G1;
                    end
                end
                S_G1: r_state <= S_G2;
                S_G2: r_state <= S_ROT;
                S_ROT: begin
                    r_step  <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_step <= r_step + 1'b1;
                    if (32'(r_step) == MAX_JOINTS) begin
                        r_state <= S_RES;
                    end
                end
                S_RES: begin
                    r_k     <= '0;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (take) begin
                        r_res.joint       <= r_k[2:0];
                        r_res.torque      <= i_head_torque;
                        r_res.saturated   <= i_head_sat;
                        r_res.last        <= (r_k == r_n - 1'b1);
                        r_k               <= r_k + 1'b1;
                        if (r_k == r_n - 1'b1) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall = r_state != S_IDLE;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    a_compute_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_req.kind == KIND_COMPUTE |=> o_stall)
        else $error("compute request did not stall the input");
    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> r_k < r_n)
        else $error("more results emitted than joints in use");
    a_last_joint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && r_k == r_n - 1'b1 |=> o_valid && o_res.last && r_state == S_IDLE)
        else $error("final result not flagged as last");

endmodule

FILE: hw/rtl/pd_control_inertia_compensation_unit.sv
// ----------------------------------------------------------------------------
// pd_control_inertia_compensation_unit: joint-space PD with inertia and
// gravity compensation
//
//   channel  | direction | signals
//   ---------+-----------+--------------------------------------
//   request  | in        | i_valid, o_stall, i_req
//   result   | out       | o_valid, i_stall, o_res
//   config   | in        | i_cfg_we, i_cfg_idx, i_cfg_data
//
// A joint or inertia request is loaded into its cell when accepted. A compute
// request computes gamma, passes the gamma ring once around the cells, sums
// the torques, then drains one result per cycle unless i_stall holds it.
// Reset is synchronous and restores the gain, mode and count registers.
// o_stall is high from a compute request until its last result is loaded.
// ----------------------------------------------------------------------------
module pd_control_inertia_compensation_unit
    import pdic_pkg::*;
#(
    parameter int MAX_JOINTS = 8,
    parameter int FRAC_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_in_req     i_req,
    output logic        o_stall,
    output logic        o_valid,
    output t_out_res    o_res,
    input  logic        i_stall,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [30:0] i_cfg_data
);

    localparam int IW = $clog2(MAX_JOINTS + 1);

    logic [30:0] r_kp, r_kd;
    logic [1:0]  r_mode;
    logic [3:0]  r_count;

    t_cell_ctrl ctrl;

    logic signed [31:0] circ     [MAX_JOINTS];
    logic [IW-1:0]      circ_idx [MAX_JOINTS];
    logic               any_chain [MAX_JOINTS+1];
    logic signed [31:0] res_t    [MAX_JOINTS+1];
    logic               res_s    [MAX_JOINTS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp    <= 31'(KP_RESET_INT << FRAC_BITS);
            r_kd    <= 31'(KD_RESET_INT << FRAC_BITS);
            r_mode  <= MODE_FULL;
            r_count <= 4'd8;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KP:    r_kp    <= i_cfg_data;
                CFG_KD:    r_kd    <= i_cfg_data;
                CFG_MODE:  r_mode  <= i_cfg_data[1:0];
                CFG_COUNT: r_count <= i_cfg_data[3:0];
                default:   r_count <= r_count;
            endcase
        end
    end

    pdic_ctrl #(.MAX_JOINTS(MAX_JOINTS)) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_req         (i_req),
        .o_stall       (o_stall),
        .o_valid       (o_valid),
        .o_res         (o_res),
        .i_stall       (i_stall),
        .i_mode        (r_mode),
        .i_count       (r_count),
        .i_head_torque (res_t[0]),
        .i_head_sat    (res_s[0]),
        .o_ctrl        (ctrl)
    );

    assign any_chain[0]     = 1'b0;
    assign res_t[MAX_JOINTS] = '0;
    assign res_s[MAX_JOINTS] = 1'b0;

    for (genvar g = 0; g < MAX_JOINTS; g++) begin : g_cell
        pdic_cell #(
            .MAX_JOINTS (MAX_JOINTS),
            .FRAC_BITS  (FRAC_BITS),
            .IDX        (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (ctrl),
            .i_req        (i_req),
            .i_kp         (r_kp),
            .i_kd         (r_kd),
            .i_circ       (circ[(g + 1) % MAX_JOINTS]),
            .i_circ_idx   (circ_idx[(g + 1) % MAX_JOINTS]),
            .o_circ       (circ[g]),
            .o_circ_idx   (circ_idx[g]),
            .i_any_in     (any_chain[g]),
            .o_any_out    (any_chain[g+1]),
            .i_any_all    (any_chain[MAX_JOINTS]),
            .i_res_torque (res_t[g+1]),
            .i_res_sat    (res_s[g+1]),
            .o_res_torque (res_t[g]),
            .o_res_sat    (res_s[g])
        );
    end

endmodule
